### hw/rtl/frp_pkg.sv
// ----------------------------------------------------------------------------
// frp_pkg
// Types, character constants and the per-byte parse step of the FASTA
// record parser.
// ----------------------------------------------------------------------------
package frp_pkg;

  localparam int unsigned LineBits = 32;

  localparam logic [7:0] ChGt  = 8'h3E;
  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChSp  = 8'h20;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChFf  = 8'h0C;

  typedef enum logic [2:0] {
    KindIdByte  = 3'd0,
    KindIdEnd   = 3'd1,
    KindSeqByte = 3'd2,
    KindRecEnd  = 3'd3,
    KindError   = 3'd4,
    KindDone    = 3'd5
  } kind_e;

  typedef enum logic [5:0] {
    ModeAwait = 6'b000001,
    ModeId    = 6'b000010,
    ModeHrest = 6'b000100,
    ModeSeq   = 6'b001000,
    ModeErr   = 6'b010000,
    ModeDone  = 6'b100000
  } mode_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_byte;
    logic [31:0] line_number;
    logic        last;
  } out_word_t;

  // Up to three words caused by one input word.
  typedef struct packed {
    logic [1:0]            cnt;
    out_word_t [2:0]       res;
  } res_grp_t;

  typedef struct packed {
    mode_e mode;
    logic  als;   // at line start
    logic  pcr;   // CR held back
    logic  ids;   // ID has a byte
    logic  rec;   // record open
  } st_t;

  typedef struct packed {
    st_t        st;
    logic       emit;
    kind_e      kind;
    logic [7:0] dat;
  } take_t;

  localparam st_t StReset = '{mode: ModeAwait, als: 1'b1, pcr: 1'b0,
                              ids: 1'b0, rec: 1'b0};

  function automatic out_word_t mk_word(kind_e kind, logic [7:0] dat,
                                        logic [31:0] ln);
    out_word_t w;
    w.kind        = kind;
    w.out_byte    = dat;
    w.line_number = ln;
    w.last        = 1'b0;
    return w;
  endfunction

  function automatic take_t take_byte(st_t st, logic [7:0] b);
    take_t t;
    logic  is_lf;
    logic  is_sep;
    is_lf  = (b == ChLf);
    is_sep = (b == ChSp) || (b == ChTab) || (b == ChFf);
    t.st   = st;
    t.emit = 1'b0;
    t.kind = KindIdByte;
    t.dat  = 8'h00;
    case (st.mode)
      ModeAwait: begin
        if (is_lf) begin
          t.st.als = 1'b1;
        end else if (b == ChGt) begin
          t.st.mode = ModeId;
          t.st.ids  = 1'b0;
          t.st.als  = 1'b0;
        end else begin
          t.st.mode = ModeErr;
          t.emit    = 1'b1;
          t.kind    = KindError;
        end
      end
      ModeId: begin
        if (is_lf || is_sep) begin
          if (!st.ids) begin
            t.st.mode = ModeErr;
            t.emit    = 1'b1;
            t.kind    = KindError;
          end else begin
            t.emit   = 1'b1;
            t.kind   = KindIdEnd;
            t.st.rec = 1'b1;
            if (is_lf) begin
              t.st.mode = ModeSeq;
              t.st.als  = 1'b1;
            end else begin
              t.st.mode = ModeHrest;
            end
          end
        end else begin
          t.emit   = 1'b1;
          t.kind   = KindIdByte;
          t.dat    = b;
          t.st.ids = 1'b1;
        end
      end
      ModeHrest: begin
        if (is_lf) begin
          t.st.mode = ModeSeq;
          t.st.als  = 1'b1;
        end
      end
      ModeSeq: begin
        if (is_lf) begin
          t.st.als = 1'b1;
        end else if (st.als && (b == ChGt)) begin
          t.emit    = 1'b1;
          t.kind    = KindRecEnd;
          t.st.rec  = 1'b0;
          t.st.mode = ModeId;
          t.st.ids  = 1'b0;
          t.st.als  = 1'b0;
        end else begin
          t.emit   = 1'b1;
          t.kind   = KindSeqByte;
          t.dat    = b;
          t.st.als = 1'b0;
        end
      end
      default: begin
      end
    endcase
    return t;
  endfunction

endpackage

### hw/rtl/frp_core.sv
// ----------------------------------------------------------------------------
// frp_core
// Input register, parser state and the single-pass step that turns one
// input word into a group of up to three result words.
// ----------------------------------------------------------------------------
module frp_core import frp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_word_t in_word_i,
  output logic     grp_vld_o,
  output res_grp_t grp_o,
  input  logic     grp_space_i
);

  localparam logic [LineBits-1:0] LineMax = {LineBits{1'b1}};

  logic                in_vld_q;
  in_word_t            in_q;
  st_t                 st_q, st_d;
  logic [LineBits-1:0] line_q, line_d;
  res_grp_t            grp;
  logic                commit;

  always_comb begin
    logic [63:0] ext;
    logic [31:0] ln;
    logic [7:0]  b;
    logic [1:0]  n;
    logic        stop;
    take_t       t;

    st_d   = st_q;
    line_d = line_q;
    b      = in_q.data_byte;
    n      = 2'd0;
    stop   = 1'b0;
    grp    = '0;
    t      = '0;

    if ((st_q.mode != ModeErr) && (st_q.mode != ModeDone) && !in_q.cmd &&
        st_q.als && !st_q.pcr && (line_q != LineMax)) begin
      line_d = line_q + LineBits'(1);
    end
    ext = 64'(line_d);
    ln  = (ext > 64'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : ext[31:0];

    if (st_q.mode == ModeErr) begin
      grp.res[n] = mk_word(KindError, 8'h00, ln);
      n = n + 2'd1;
    end else if (st_q.mode == ModeDone) begin
      grp.res[n] = mk_word(KindDone, 8'h00, ln);
      n = n + 2'd1;
    end else if (in_q.cmd) begin
      st_d.pcr = 1'b0;
      if ((st_q.mode == ModeId) && !st_q.ids) begin
        st_d.mode  = ModeErr;
        grp.res[n] = mk_word(KindError, 8'h00, ln);
        n = n + 2'd1;
      end else begin
        if (st_q.mode == ModeId) begin
          grp.res[n] = mk_word(KindIdEnd, 8'h00, ln);
          n = n + 2'd1;
          st_d.rec = 1'b1;
        end
        if (st_d.rec) begin
          grp.res[n] = mk_word(KindRecEnd, 8'h00, ln);
          n = n + 2'd1;
          st_d.rec = 1'b0;
        end
        st_d.mode  = ModeDone;
        grp.res[n] = mk_word(KindDone, 8'h00, ln);
        n = n + 2'd1;
      end
    end else begin
      st_d.pcr = 1'b0;
      // held CR not followed by LF is parsed as an ordinary byte
      if (st_q.pcr && (b != ChLf)) begin
        t    = take_byte(st_d, ChCr);
        st_d = t.st;
        if (t.emit) begin
          grp.res[n] = mk_word(t.kind, t.dat, ln);
          n = n + 2'd1;
        end
        stop = (st_d.mode == ModeErr);
      end
      if (!stop) begin
        if (b == ChCr) begin
          st_d.pcr = 1'b1;
        end else begin
          t    = take_byte(st_d, b);
          st_d = t.st;
          if (t.emit) begin
            grp.res[n] = mk_word(t.kind, t.dat, ln);
            n = n + 2'd1;
          end
        end
      end
    end

    if (n != 2'd0) begin
      grp.res[n - 2'd1].last = 1'b1;
    end
    grp.cnt = n;
  end

  assign commit     = in_vld_q && ((grp.cnt == 2'd0) || grp_space_i);
  assign in_ready_o = !in_vld_q || commit;
  assign grp_vld_o  = in_vld_q && (grp.cnt != 2'd0);
  assign grp_o      = grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      st_q     <= StReset;
      line_q   <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (commit) begin
        st_q   <= st_d;
        line_q <= line_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_word_i;
    end
  end

endmodule

### hw/rtl/frp_out_buf.sv
// ----------------------------------------------------------------------------
// frp_out_buf
// Result buffer: takes a group of up to three words and hands them out
// one per handshake.
// ----------------------------------------------------------------------------
module frp_out_buf import frp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      grp_vld_i,
  input  res_grp_t  grp_i,
  output logic      grp_space_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  out_word_t [2:0] ent_q;
  logic [1:0]      cnt_q;
  logic            pop;
  logic            load;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_word_o  = ent_q[0];
  assign pop         = out_valid_o && out_ready_i;
  assign grp_space_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);
  assign load        = grp_vld_i && grp_space_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load) begin
      cnt_q <= grp_i.cnt;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ent_q <= grp_i.res;
    end else if (pop) begin
      ent_q[0] <= ent_q[1];
      ent_q[1] <= ent_q[2];
    end
  end

endmodule

### hw/rtl/fasta_record_parser.sv
// ----------------------------------------------------------------------------
// fasta_record_parser
// Streaming FASTA parser: text bytes in, ID bytes, sequence bytes and
// record marks out.
// ----------------------------------------------------------------------------
//  channel   ports                                     word
//  input     in_valid_i / in_ready_o / in_word_i       cmd, data_byte
//  output    out_valid_o / out_ready_i / out_word_o    kind, out_byte,
//                                                      line_number, last
//
//  One input word per cycle while the result buffer has space. The input
//  register feeds the combinational step, whose group is loaded into the
//  three-entry result buffer, which offers the first result. After a word
//  with two or three results, the next word with results waits as it drains.
//  Words that make no result pass even while the buffer is full.
//  Reset is asynchronous, active low; it clears state and both buffers.
// ----------------------------------------------------------------------------
module fasta_record_parser import frp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  logic     grp_vld;
  res_grp_t grp;
  logic     grp_space;

  frp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .grp_vld_o   (grp_vld),
    .grp_o       (grp),
    .grp_space_i (grp_space)
  );

  frp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_vld_i   (grp_vld),
    .grp_i       (grp),
    .grp_space_o (grp_space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
